### rtl/core/tpps_pkg.sv
// shared types and constants for the transmit ping-pong slot scheduler
// no dependencies
`timescale 1ns / 1ps

package tpps_pkg;

   // overflow queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int TAG_W   = 8;
   localparam int LEN_W   = 11;
   localparam int PAGE_W  = 8;
   localparam int PPS_W   = 4;
   localparam int ACT_W   = 3;
   localparam int CSR_W   = 8;
   localparam int QENT_W  = TAG_W + LEN_W;

   // request kinds
   localparam logic REQ_SEND     = 1'b0;
   localparam logic REQ_COMPLETE = 1'b1;

   // result actions
   localparam logic [ACT_W-1:0] ACT_COPY    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_START   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_QUEUED  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DROPPED = 3'd3;
   localparam logic [ACT_W-1:0] ACT_NOTHING = 3'd4;

   // register indexes
   localparam logic CSR_TX_BASE_PAGE   = 1'b0;
   localparam logic CSR_PAGES_PER_SLOT = 1'b1;

   // register reset values
   localparam logic [PAGE_W-1:0] BASE_PAGE_RESET = 8'h40;
   localparam logic [PPS_W-1:0]  PPS_RESET       = 4'd6;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic              slot;
      logic [PAGE_W-1:0] start_page;
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  len;
   } result_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic two;
   } status_type;

endpackage

### rtl/core/tpps_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tpps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### rtl/core/tpps_ctrl.sv
// handshake controller for the slot scheduler
// depends on tpps_pkg
`timescale 1ns / 1ps

module tpps_ctrl
   import tpps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_OUT0 = 2'd2;
   localparam logic [1:0] ST_OUT1 = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.eval    = 1'b0;
      cmd.sel     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_OUT0;
         end
         ST_OUT0: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = status.two ? ST_OUT1 : ST_IDLE;
            end
         end
         ST_OUT1: begin
            rsp_valid = 1'b1;
            cmd.sel   = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/tpps_dp.sv
// slot scheduler datapath: slot state, queue pointers, config, result records
// depends on tpps_pkg and tpps_ram
`timescale 1ns / 1ps

module tpps_dp
   import tpps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              req_type,
   input  logic [TAG_W-1:0]  req_frame_tag,
   input  logic [LEN_W-1:0]  req_frame_len,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   output logic [ACT_W-1:0]  rsp_action,
   output logic              rsp_slot,
   output logic [PAGE_W-1:0] rsp_start_page,
   output logic [TAG_W-1:0]  rsp_out_tag,
   output logic [LEN_W-1:0]  rsp_out_len,
   output logic              rsp_last
);

   // config
   logic [PAGE_W-1:0] base_ff;
   logic [PPS_W-1:0]  pps_ff;

   // scheduler state
   logic              busy_ff, busy_in;
   logic              cur_ff, cur_in;
   logic [LEN_W-1:0]  s0_len_ff, s1_len_ff;
   logic [TAG_W-1:0]  s0_tag_ff, s1_tag_ff;
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // captured transaction
   logic              type_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [LEN_W-1:0]  len_ff;

   // result records
   result_type r0_ff, r0_in;
   result_type r1_ff, r1_in;
   logic       two_ff, two_in;

   // slot write
   logic              sw_en;
   logic              sw_slot;
   logic [TAG_W-1:0]  sw_tag;
   logic [LEN_W-1:0]  sw_len;

   // queue ram
   logic              q_we;
   logic [QPTR_W-1:0] q_tail;
   logic [QCNT_W:0]   tail_sum;
   logic [QENT_W-1:0] q_rdata;
   logic [TAG_W-1:0]  q_tag;
   logic [LEN_W-1:0]  q_len;

   logic [LEN_W-1:0]  cur_len, oth_len;
   logic [TAG_W-1:0]  cur_tag, oth_tag;
   logic [PAGE_W-1:0] page0, page1, cur_page, oth_page;
   logic              has_q, q_full;
   result_type        res_copy, res_start, res_nothing;

   tpps_ram #(
      .WIDTH(QENT_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .wr_en  (q_we),
      .wr_addr(q_tail),
      .wr_data({tag_ff, len_ff}),
      .rd_addr(head_ff),
      .rd_data(q_rdata)
   );

   assign q_tag = q_rdata[QENT_W-1:LEN_W];
   assign q_len = q_rdata[LEN_W-1:0];

   // tail = (head + count) mod depth
   always_comb begin
      tail_sum = {{(QCNT_W + 1 - QPTR_W){1'b0}}, head_ff} + {1'b0, count_ff};
      if (tail_sum >= (QCNT_W + 1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (QCNT_W + 1)'(QUEUE_DEPTH);
      end
      q_tail = tail_sum[QPTR_W-1:0];
   end

   assign page0    = base_ff;
   assign page1    = base_ff + {{(PAGE_W - PPS_W){1'b0}}, pps_ff};
   assign cur_len  = cur_ff ? s1_len_ff : s0_len_ff;
   assign oth_len  = cur_ff ? s0_len_ff : s1_len_ff;
   assign cur_tag  = cur_ff ? s1_tag_ff : s0_tag_ff;
   assign oth_tag  = cur_ff ? s0_tag_ff : s1_tag_ff;
   assign cur_page = cur_ff ? page1 : page0;
   assign oth_page = cur_ff ? page0 : page1;
   assign has_q    = (count_ff != '0);
   assign q_full   = (count_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      busy_in  = busy_ff;
      cur_in   = cur_ff;
      head_in  = head_ff;
      count_in = count_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      two_in   = two_ff;
      sw_en    = 1'b0;
      sw_slot  = cur_ff;
      sw_tag   = tag_ff;
      sw_len   = len_ff;
      q_we     = 1'b0;

      res_nothing = '{action: ACT_NOTHING, slot: 1'b0, start_page: '0, tag: '0, len: '0};
      res_copy    = '{action: ACT_COPY, slot: cur_ff, start_page: cur_page,
                      tag: q_tag, len: q_len};
      res_start   = '{action: ACT_START, slot: ~cur_ff, start_page: oth_page,
                      tag: oth_tag, len: oth_len};

      if (cmd.eval) begin
         if (type_ff == REQ_SEND) begin
            two_in = 1'b0;
            r1_in  = r0_ff;
            if (!busy_ff) begin
               // idle: load current slot and start it right away
               sw_en   = 1'b1;
               busy_in = 1'b1;
               two_in  = 1'b1;
               r0_in   = '{action: ACT_COPY, slot: cur_ff, start_page: cur_page,
                           tag: tag_ff, len: len_ff};
               r1_in   = '{action: ACT_START, slot: cur_ff, start_page: cur_page,
                           tag: tag_ff, len: len_ff};
            end else if (oth_len == '0) begin
               sw_en   = 1'b1;
               sw_slot = ~cur_ff;
               r0_in   = '{action: ACT_COPY, slot: ~cur_ff, start_page: oth_page,
                           tag: tag_ff, len: len_ff};
            end else if (!q_full) begin
               q_we     = 1'b1;
               count_in = count_ff + QCNT_W'(1);
               r0_in    = '{action: ACT_QUEUED, slot: 1'b0, start_page: '0,
                            tag: tag_ff, len: len_ff};
            end else begin
               r0_in    = '{action: ACT_DROPPED, slot: 1'b0, start_page: '0,
                            tag: tag_ff, len: len_ff};
            end
         end else begin
            // completion: free current slot, refill from queue head, swap
            sw_en   = 1'b1;
            sw_slot = cur_ff;
            sw_tag  = has_q ? q_tag : cur_tag;
            sw_len  = has_q ? q_len : '0;
            if (has_q) begin
               count_in = count_ff - QCNT_W'(1);
               head_in  = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : head_ff + QPTR_W'(1);
            end
            cur_in  = ~cur_ff;
            busy_in = (oth_len != '0);
            two_in  = has_q && (oth_len != '0);
            r1_in   = res_start;
            if (has_q) begin
               r0_in = res_copy;
            end else if (oth_len != '0) begin
               r0_in = res_start;
            end else begin
               r0_in = res_nothing;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_PAGE_RESET;
         pps_ff    <= PPS_RESET;
         busy_ff   <= 1'b0;
         cur_ff    <= 1'b0;
         s0_len_ff <= '0;
         s1_len_ff <= '0;
         head_ff   <= '0;
         count_ff  <= '0;
         two_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TX_BASE_PAGE:   base_ff <= csr_wdata;
               CSR_PAGES_PER_SLOT: pps_ff  <= csr_wdata[PPS_W-1:0];
               default: ;
            endcase
         end
         busy_ff  <= busy_in;
         cur_ff   <= cur_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         two_ff   <= two_in;
         if (sw_en && !sw_slot) begin
            s0_len_ff <= sw_len;
         end
         if (sw_en && sw_slot) begin
            s1_len_ff <= sw_len;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         tag_ff  <= req_frame_tag;
         len_ff  <= req_frame_len;
      end
      if (sw_en && !sw_slot) begin
         s0_tag_ff <= sw_tag;
      end
      if (sw_en && sw_slot) begin
         s1_tag_ff <= sw_tag;
      end
      r0_ff <= r0_in;
      r1_ff <= r1_in;
   end

   assign status.two = two_ff;

   always_comb begin
      if (cmd.sel) begin
         rsp_action     = r1_ff.action;
         rsp_slot       = r1_ff.slot;
         rsp_start_page = r1_ff.start_page;
         rsp_out_tag    = r1_ff.tag;
         rsp_out_len    = r1_ff.len;
      end else begin
         rsp_action     = r0_ff.action;
         rsp_slot       = r0_ff.slot;
         rsp_start_page = r0_ff.start_page;
         rsp_out_tag    = r0_ff.tag;
         rsp_out_len    = r0_ff.len;
      end
      rsp_last = cmd.sel | ~two_ff;
   end

endmodule

### rtl/core/tx_ping_pong_slot_scheduler.sv
// top level of the transmit ping-pong slot scheduler
// depends on tpps_pkg, tpps_ctrl, tpps_dp (and tpps_ram through tpps_dp)
`timescale 1ns / 1ps

// usage
//   req channel (valid/ready): one transaction is either a send request
//   (req_type 0, tag and length) or a transmit-complete event (req_type 1)
//   rsp channel (valid/ready): one or two result transactions per request,
//   rsp_last marks the final one; a send while idle gives copy then start,
//   a completion may give a refill copy then a start of the other slot
//   csr port: csr_we with csr_index 0 writes the slot-zero base page,
//   index 1 the pages per slot; write only while the block is idle
// sequencing
//   one request at a time: accept, an evaluate step, then the results;
//   the first result is offered in the state after the evaluate step;
//   a request runs through the idle, evaluate and one or two result
//   states, plus any rsp stall
//   the pace is set by the evaluate step, which reads the queue head
//   from the registered-read queue ram, and by the result handoff
// reset
//   synchronous; slots free, transmitter idle, queue empty, registers
//   back to base page 0x40 and 6 pages per slot; no clearing pass
// stalls
//   a low rsp_ready holds the current result; req_ready stays low
//   until the last result of the transaction has been taken

module tx_ping_pong_slot_scheduler
   import tpps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [TAG_W-1:0]  req_frame_tag,
   input  logic [LEN_W-1:0]  req_frame_len,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ACT_W-1:0]  rsp_action,
   output logic              rsp_slot,
   output logic [PAGE_W-1:0] rsp_start_page,
   output logic [TAG_W-1:0]  rsp_out_tag,
   output logic [LEN_W-1:0]  rsp_out_len,
   output logic              rsp_last,
   // register write port
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencing: idle / evaluate / first result / second result
   tpps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // slot state, overflow queue and result records
   tpps_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_type      (req_type),
      .req_frame_tag (req_frame_tag),
      .req_frame_len (req_frame_len),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_action    (rsp_action),
      .rsp_slot      (rsp_slot),
      .rsp_start_page(rsp_start_page),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_out_len   (rsp_out_len),
      .rsp_last      (rsp_last)
   );

endmodule

### rtl/core/tpps_checker.sv
// port-level checks for the transmit ping-pong slot scheduler, bound to the top
// depends on tpps_pkg
`timescale 1ns / 1ps

module tpps_checker
   import tpps_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ACT_W-1:0]  rsp_action,
   input logic              rsp_slot,
   input logic [PAGE_W-1:0] rsp_start_page,
   input logic [TAG_W-1:0]  rsp_out_tag,
   input logic [LEN_W-1:0]  rsp_out_len,
   input logic              rsp_last
);

   // one transaction in flight: never ready while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready high while a result is offered");

   // an accepted request blocks the input on the next cycle
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   // a non-final result is followed right away by another one
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (rsp_valid && rsp_action == ACT_START))
      else $error("missing second result");

   // nothing, queued and dropped results always stand alone
   a_single_kinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == ACT_NOTHING || rsp_action == ACT_QUEUED ||
                     rsp_action == ACT_DROPPED)) |-> rsp_last)
      else $error("single-result action not marked last");

   // results without a slot carry no slot or page; nothing carries no frame
   a_slotless_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == ACT_NOTHING || rsp_action == ACT_QUEUED ||
                     rsp_action == ACT_DROPPED)) |->
      (!rsp_slot && rsp_start_page == '0 &&
       (rsp_action != ACT_NOTHING || (rsp_out_tag == '0 && rsp_out_len == '0))))
      else $error("slotless result with nonzero fields");

endmodule

bind tx_ping_pong_slot_scheduler tpps_checker u_tpps_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the transmit ping-pong slot scheduler
// depends on tpps_pkg and the tx_ping_pong_slot_scheduler rtl only

module tb_top;
   import tpps_pkg::*;

   // one result transaction as seen on the rsp channel
   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic              slot;
      logic [PAGE_W-1:0] start_page;
      logic [TAG_W-1:0]  out_tag;
      logic [LEN_W-1:0]  out_len;
      logic              last;
   } sched_result_type;

   // a frame waiting in the overflow backlog
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [LEN_W-1:0] len;
   } frame_type;

   // receiver backpressure patterns
   typedef enum int {
      RSP_ALWAYS,
      RSP_RANDOM,
      RSP_BURSTY,
      RSP_TOGGLE
   } rsp_pattern_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_type = REQ_SEND;
   logic [TAG_W-1:0]  req_frame_tag = '0;
   logic [LEN_W-1:0]  req_frame_len = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ACT_W-1:0]  rsp_action;
   logic              rsp_slot;
   logic [PAGE_W-1:0] rsp_start_page;
   logic [TAG_W-1:0]  rsp_out_tag;
   logic [LEN_W-1:0]  rsp_out_len;
   logic              rsp_last;
   logic              csr_we = 1'b0;
   logic              csr_index = CSR_TX_BASE_PAGE;
   logic [CSR_W-1:0]  csr_wdata = '0;

   tx_ping_pong_slot_scheduler dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_frame_tag  (req_frame_tag),
      .req_frame_len  (req_frame_len),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_action     (rsp_action),
      .rsp_slot       (rsp_slot),
      .rsp_start_page (rsp_start_page),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_out_len    (rsp_out_len),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #2000000;
      $display("tx_ping_pong_slot_scheduler regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // scheduler prediction: own copy of slots, backlog and registers
   // ------------------------------------------------------------------
   logic [PAGE_W-1:0] sched_base_page;
   logic [PPS_W-1:0]  sched_pages_per_slot;
   logic              sched_busy;
   logic              sched_cur_slot;
   logic [LEN_W-1:0]  sched_slot_len [2];
   logic [TAG_W-1:0]  sched_slot_tag [2];
   frame_type         backlog [$];
   sched_result_type  expected_results [$];
   int                fail_count = 0;

   function automatic void reset_scheduler_copy();
      sched_base_page      = BASE_PAGE_RESET;
      sched_pages_per_slot = PPS_RESET;
      sched_busy           = 1'b0;
      sched_cur_slot       = 1'b0;
      sched_slot_len[0]    = '0;
      sched_slot_len[1]    = '0;
      sched_slot_tag[0]    = '0;
      sched_slot_tag[1]    = '0;
      backlog.delete();
   endfunction

   // slot one sits pages_per_slot above the base, wrapping at 256
   function automatic logic [PAGE_W-1:0] page_of_slot(input logic s);
      return sched_base_page + (s ? PAGE_W'(sched_pages_per_slot) : PAGE_W'(0));
   endfunction

   function automatic sched_result_type make_result(input logic [ACT_W-1:0] action,
                                                    input logic s,
                                                    input logic [PAGE_W-1:0] page,
                                                    input logic [TAG_W-1:0] tag,
                                                    input logic [LEN_W-1:0] len);
      sched_result_type r;
      r.action     = action;
      r.slot       = s;
      r.start_page = page;
      r.out_tag    = tag;
      r.out_len    = len;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic sched_result_type slot_result(input logic [ACT_W-1:0] action,
                                                    input logic s);
      return make_result(action, s, page_of_slot(s), sched_slot_tag[s], sched_slot_len[s]);
   endfunction

   // works out the one or two results caused by an accepted request
   function automatic void predict_schedule(input logic rtype,
                                            input logic [TAG_W-1:0] tag,
                                            input logic [LEN_W-1:0] len);
      sched_result_type res [2];
      int               n;
      logic             other;
      frame_type        head;
      n = 0;
      other = ~sched_cur_slot;
      if (rtype == REQ_SEND) begin
         if (!sched_busy) begin
            // idle: overwrite the current slot and start it right away
            sched_slot_tag[sched_cur_slot] = tag;
            sched_slot_len[sched_cur_slot] = len;
            res[0] = slot_result(ACT_COPY, sched_cur_slot);
            sched_busy = 1'b1;
            res[1] = slot_result(ACT_START, sched_cur_slot);
            n = 2;
         end else if (sched_slot_len[other] == '0) begin
            // a zero-length frame leaves its slot looking free
            sched_slot_tag[other] = tag;
            sched_slot_len[other] = len;
            res[0] = slot_result(ACT_COPY, other);
            n = 1;
         end else if (backlog.size() < QUEUE_DEPTH) begin
            head.tag = tag;
            head.len = len;
            backlog.push_back(head);
            res[0] = make_result(ACT_QUEUED, 1'b0, '0, tag, len);
            n = 1;
         end else begin
            res[0] = make_result(ACT_DROPPED, 1'b0, '0, tag, len);
            n = 1;
         end
      end else begin
         // completion frees the current slot, refills it from any backlog, then swaps slots
         sched_busy = 1'b0;
         sched_slot_len[sched_cur_slot] = '0;
         if (backlog.size() > 0) begin
            head = backlog.pop_front();
            sched_slot_tag[sched_cur_slot] = head.tag;
            sched_slot_len[sched_cur_slot] = head.len;
            res[n] = slot_result(ACT_COPY, sched_cur_slot);
            n++;
         end
         sched_cur_slot = other;
         if (sched_slot_len[sched_cur_slot] != '0) begin
            sched_busy = 1'b1;
            res[n] = slot_result(ACT_START, sched_cur_slot);
            n++;
         end
         if (n == 0) begin
            res[0] = make_result(ACT_NOTHING, 1'b0, '0, '0, '0);
            n = 1;
         end
      end
      res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
   endfunction

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [LEN_W-1:0] want,
                                       input logic [LEN_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_result();
      sched_result_type want;
      if (expected_results.size() == 0) begin
         $error("result with nothing expected: action %0d tag %0d", rsp_action, rsp_out_tag);
         fail_count++;
         return;
      end
      want = expected_results.pop_front();
      check_field("action", LEN_W'(want.action), LEN_W'(rsp_action));
      check_field("slot", LEN_W'(want.slot), LEN_W'(rsp_slot));
      check_field("start_page", LEN_W'(want.start_page), LEN_W'(rsp_start_page));
      check_field("out_tag", LEN_W'(want.out_tag), LEN_W'(rsp_out_tag));
      check_field("out_len", want.out_len, rsp_out_len);
      check_field("last", LEN_W'(want.last), LEN_W'(rsp_last));
   endfunction

   // both channels sampled at the edge, before this edge's updates land;
   // prediction first so a same-edge result would still find it
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) predict_schedule(req_type, req_frame_tag, req_frame_len);
         if (rsp_valid && rsp_ready) check_result();
      end
   end

   // ------------------------------------------------------------------
   // receiver: switches between backpressure patterns after runs of random length
   // ------------------------------------------------------------------
   rsp_pattern_type rsp_pattern = RSP_ALWAYS;
   int              rsp_pattern_left = 0;
   int              rsp_hold = 0;

   always @(posedge clock) begin
      if (rsp_pattern_left == 0) begin
         rsp_pattern      = rsp_pattern_type'($urandom_range(0, 3));
         rsp_pattern_left = $urandom_range(16, 96);
      end else begin
         rsp_pattern_left--;
      end
      case (rsp_pattern)
         RSP_ALWAYS: rsp_ready <= 1'b1;
         RSP_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         RSP_BURSTY: begin
            // one ready cycle, then a stall of random length
            if (rsp_hold == 0) begin
               rsp_ready <= 1'b1;
               rsp_hold = $urandom_range(1, 5);
            end else begin
               rsp_ready <= 1'b0;
               rsp_hold--;
            end
         end
         default: rsp_ready <= rsp_pattern_left[0];
      endcase
   end

   // ------------------------------------------------------------------
   // sender: bursts of random length separated by random gaps
   // ------------------------------------------------------------------
   int burst_left = 0;

   // returns in the time step of the accepting edge with valid still high,
   // so a following call keeps the channel busy without a bubble
   task automatic send_request(input logic rtype, input logic [TAG_W-1:0] tag,
                               input logic [LEN_W-1:0] len);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_type      <= rtype;
      req_frame_tag <= tag;
      req_frame_len <= len;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // drop valid after the last accepted transaction and let results drain
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      if (index == CSR_TX_BASE_PAGE) sched_base_page = data[PAGE_W-1:0];
      else sched_pages_per_slot = data[PPS_W-1:0];
   endtask

   // only called with the block idle; upper data bits of the slot size are junk
   task automatic apply_settings(input logic [PAGE_W-1:0] base,
                                 input logic [PPS_W-1:0] pps);
      logic [CSR_W-PPS_W-1:0] junk;
      junk = (CSR_W - PPS_W)'($urandom);
      write_register(CSR_TX_BASE_PAGE, base);
      write_register(CSR_PAGES_PER_SLOT, {junk, pps});
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // mostly in-range lengths, with zero and out-of-range values mixed in
   function automatic logic [LEN_W-1:0] random_length();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return LEN_W'($urandom_range(1537, 2047));
         2: return LEN_W'($urandom);
         3: return LEN_W'(1536);
         default: return LEN_W'($urandom_range(1, 1536));
      endcase
   endfunction

   // episodes of send-heavy, balanced and drain-heavy traffic;
   // send-heavy ones pile the backlog up until frames get dropped
   task automatic run_random_traffic(input int n_items);
      int send_pct;
      int episode_left;
      episode_left = 0;
      send_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (episode_left == 0) begin
            case ($urandom_range(0, 2))
               0: send_pct = 90;
               1: send_pct = 50;
               default: send_pct = 25;
            endcase
            episode_left = $urandom_range(10, 50);
         end
         episode_left--;
         send_request(($urandom_range(1, 100) <= send_pct) ? REQ_SEND : REQ_COMPLETE,
                      TAG_W'($urandom), random_length());
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // slot handover under reset register values: completion while idle,
   // both slots filled, backlog refill, zero lengths, overwrite while idle
   task automatic test_slot_handover();
      send_request(REQ_COMPLETE, 8'h00, 11'd0);     // idle completion, nothing
      send_request(REQ_SEND, 8'h00, 11'd1);         // copy and start
      send_request(REQ_SEND, 8'hFF, 11'd1536);      // other slot
      send_request(REQ_SEND, 8'hA5, 11'd2047);      // backlog, length above range
      send_request(REQ_SEND, 8'h5A, 11'd0);         // backlog, zero length
      send_request(REQ_COMPLETE, 8'hFF, 11'h7FF);   // refill and start
      send_request(REQ_COMPLETE, 8'h12, 11'h2AA);   // refill with zero length
      send_request(REQ_COMPLETE, 8'h34, 11'h555);   // nothing to start
      send_request(REQ_COMPLETE, 8'h56, 11'd3);     // completion while idle
      send_request(REQ_SEND, 8'h3C, 11'd0);         // overwrite while idle
      send_request(REQ_SEND, 8'hC3, 11'd7);
      send_request(REQ_COMPLETE, 8'h00, 11'd0);
      send_request(REQ_SEND, 8'h11, 11'd2);
      send_request(REQ_COMPLETE, 8'h00, 11'd0);
      send_request(REQ_COMPLETE, 8'h00, 11'd0);
      wait_drained();
   endtask

   // random traffic under a series of page layouts, extremes first;
   // base 255 with a big slot size wraps slot one past page 255
   task automatic test_page_settings();
      logic [PAGE_W-1:0] base_list [6];
      logic [PPS_W-1:0]  pps_list  [6];
      base_list = '{8'd0, 8'd255, 8'd255, 8'd128, 8'd0, 8'd0};
      pps_list  = '{4'd15, 4'd15, 4'd0, 4'd6, 4'd0, 4'd0};
      base_list[4] = PAGE_W'($urandom);
      pps_list[4]  = PPS_W'($urandom_range(6, 15));
      base_list[5] = PAGE_W'($urandom);
      pps_list[5]  = PPS_W'($urandom);
      for (int k = 0; k < 6; k++) begin
         apply_settings(base_list[k], pps_list[k]);
         run_random_traffic(115);
         wait_drained();
      end
   endtask

   initial begin
      reset_scheduler_copy();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_slot_handover();
      test_page_settings();

      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("tx_ping_pong_slot_scheduler regression: pass");
      end else begin
         $display("tx_ping_pong_slot_scheduler regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/tpps_pkg.sv
rtl/core/tpps_ram.sv
rtl/core/tpps_ctrl.sv
rtl/core/tpps_dp.sv
rtl/core/tx_ping_pong_slot_scheduler.sv
rtl/core/tpps_checker.sv
tb/tb_top.sv
